// ===== rtl/windowed_track_velocity_estimator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// windowed track velocity estimator assertion macros
// shared concurrent assertion forms, sampled on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef WINDOWED_TRACK_VELOCITY_ESTIMATOR_UNIT_MACROS_SVH
`define WINDOWED_TRACK_VELOCITY_ESTIMATOR_UNIT_MACROS_SVH

// same-cycle implication
`define WTVE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WTVE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/wtve_pkg.sv =====
// ----------------------------------------------------------------------------
// wtve_pkg
// types and constants shared by the velocity estimator modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wtve_pkg;

  localparam int KIND_W  = 2;
  localparam int ID_W    = 4;
  localparam int TIME_W  = 40;
  localparam int POS_W   = 16;
  localparam int NUM_CH  = 3;
  localparam int CH_W    = 2;
  localparam int POSE_W  = POS_W * NUM_CH;
  localparam int VEL_W   = 32;
  localparam int HELD_W  = 5;
  localparam int WIN_W   = 24;
  localparam int DT_W    = TIME_W + 1;
  localparam int DIFF_W  = POS_W + 1;
  localparam int US_W    = 21;
  localparam int PROD_W  = DIFF_W + US_W;
  localparam int DIV_W   = 48;
  localparam int DCNT_W  = $clog2(DIV_W + 1);

  localparam logic [WIN_W-1:0]         WIN_RESET  = 24'd500000;
  localparam logic signed [US_W-1:0]   US_PER_SEC = 21'sd1000000;

  localparam logic [KIND_W-1:0] KIND_OURS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OPP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BALL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  // store read address select
  localparam logic [1:0] RD_SEL_EXP = 2'd0;
  localparam logic [1:0] RD_SEL_A   = 2'd1;
  localparam logic [1:0] RD_SEL_B   = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INFO_RD,
    S_APPEND,
    S_EXP_INFO,
    S_EXP_LOAD,
    S_EXP_RD,
    S_EXP_CHK,
    S_EXP_WB,
    S_VEL_INFO,
    S_VEL_LOAD,
    S_RD_A,
    S_RD_B,
    S_DT,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_PAIR_NEXT,
    S_AVG_GO,
    S_AVG_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       idle;
    logic       load_in;
    logic       info_cur;
    logic [1:0] rd_sel;
    logic       append;
    logic       exp_load;
    logic       exp_chk;
    logic       exp_wb;
    logic       vel_load;
    logic       rd_b;
    logic       dt_calc;
    logic       mul;
    logic       div_pair;
    logic       pair_acc;
    logic       pair_next;
    logic       div_avg;
    logic       avg_acc;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic exp_cnt_zero;
    logic exp_k_last;
    logic exp_trk_last;
    logic vel_short;
    logic dt_zero;
    logic ch_last;
    logic pair_last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/wtve_div.sv =====
// ----------------------------------------------------------------------------
// wtve_div
// signed radix-2 restoring divider, quotient truncated toward zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtve_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [wtve_pkg::DIV_W-1:0]    dividend,
  input  logic signed [wtve_pkg::DIV_W-1:0]    divisor,
  output logic                                 done,
  output logic signed [wtve_pkg::DIV_W-1:0]    quotient
);

  localparam int W = wtve_pkg::DIV_W;

  logic [W-1:0]                  quo;
  logic [W-1:0]                  dvs;
  logic [W:0]                    rem;
  logic [W:0]                    rem_sh;
  logic [wtve_pkg::DCNT_W-1:0]   cnt;
  logic                          busy;
  logic                          neg;

  assign rem_sh   = {rem[W-1:0], quo[W-1]};
  assign quotient = neg ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= wtve_pkg::DCNT_W'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == wtve_pkg::DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend[W-1] ? W'(-dividend) : W'(dividend);
      dvs <= divisor[W-1] ? W'(-divisor) : W'(divisor);
      rem <= '0;
      neg <= dividend[W-1] ^ divisor[W-1];
    end else if (busy) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= rem_sh - {1'b0, dvs};
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/wtve_ctrl.sv =====
// ----------------------------------------------------------------------------
// wtve_ctrl
// sequencer: append, expiry sweep, pair velocities, averaging, result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtve_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  wtve_pkg::sts_t  sts,
  output wtve_pkg::cmd_t  cmd
);

  wtve_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wtve_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wtve_pkg::S_IDLE:      if (in_valid) state_next = wtve_pkg::S_INFO_RD;
      wtve_pkg::S_INFO_RD:   state_next = sts.bad ? wtve_pkg::S_DONE : wtve_pkg::S_APPEND;
      wtve_pkg::S_APPEND:    state_next = wtve_pkg::S_EXP_INFO;
      wtve_pkg::S_EXP_INFO:  state_next = wtve_pkg::S_EXP_LOAD;
      wtve_pkg::S_EXP_LOAD:  state_next = sts.exp_cnt_zero ? wtve_pkg::S_EXP_WB
                                                           : wtve_pkg::S_EXP_RD;
      wtve_pkg::S_EXP_RD:    state_next = wtve_pkg::S_EXP_CHK;
      wtve_pkg::S_EXP_CHK:   state_next = sts.exp_k_last ? wtve_pkg::S_EXP_WB
                                                         : wtve_pkg::S_EXP_RD;
      wtve_pkg::S_EXP_WB:    state_next = sts.exp_trk_last ? wtve_pkg::S_VEL_INFO
                                                           : wtve_pkg::S_EXP_INFO;
      wtve_pkg::S_VEL_INFO:  state_next = wtve_pkg::S_VEL_LOAD;
      wtve_pkg::S_VEL_LOAD:  state_next = sts.vel_short ? wtve_pkg::S_DONE : wtve_pkg::S_RD_A;
      wtve_pkg::S_RD_A:      state_next = wtve_pkg::S_RD_B;
      wtve_pkg::S_RD_B:      state_next = wtve_pkg::S_DT;
      wtve_pkg::S_DT:        state_next = sts.dt_zero ? wtve_pkg::S_PAIR_NEXT : wtve_pkg::S_MUL;
      wtve_pkg::S_MUL:       state_next = wtve_pkg::S_DIV_GO;
      wtve_pkg::S_DIV_GO:    state_next = wtve_pkg::S_DIV_WAIT;
      wtve_pkg::S_DIV_WAIT: begin
        if (sts.div_done) begin
          state_next = sts.ch_last ? wtve_pkg::S_PAIR_NEXT : wtve_pkg::S_MUL;
        end
      end
      wtve_pkg::S_PAIR_NEXT: state_next = sts.pair_last ? wtve_pkg::S_AVG_GO : wtve_pkg::S_RD_A;
      wtve_pkg::S_AVG_GO:    state_next = wtve_pkg::S_AVG_WAIT;
      wtve_pkg::S_AVG_WAIT: begin
        if (sts.div_done) begin
          state_next = sts.ch_last ? wtve_pkg::S_DONE : wtve_pkg::S_AVG_GO;
        end
      end
      wtve_pkg::S_DONE:      if (sts.out_free) state_next = wtve_pkg::S_IDLE;
      default:               state_next = wtve_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = wtve_pkg::RD_SEL_EXP;
    case (state)
      wtve_pkg::S_IDLE: begin
        cmd.idle    = 1'b1;
        cmd.load_in = in_valid;
      end
      wtve_pkg::S_INFO_RD:   cmd.info_cur = 1'b1;
      wtve_pkg::S_APPEND:    cmd.append = 1'b1;
      wtve_pkg::S_EXP_LOAD:  cmd.exp_load = 1'b1;
      wtve_pkg::S_EXP_CHK:   cmd.exp_chk = 1'b1;
      wtve_pkg::S_EXP_WB:    cmd.exp_wb = 1'b1;
      wtve_pkg::S_VEL_INFO:  cmd.info_cur = 1'b1;
      wtve_pkg::S_VEL_LOAD:  cmd.vel_load = 1'b1;
      wtve_pkg::S_RD_A:      cmd.rd_sel = wtve_pkg::RD_SEL_A;
      wtve_pkg::S_RD_B: begin
        cmd.rd_sel = wtve_pkg::RD_SEL_B;
        cmd.rd_b   = 1'b1;
      end
      wtve_pkg::S_DT:        cmd.dt_calc = 1'b1;
      wtve_pkg::S_MUL:       cmd.mul = 1'b1;
      wtve_pkg::S_DIV_GO:    cmd.div_pair = 1'b1;
      wtve_pkg::S_DIV_WAIT:  cmd.pair_acc = sts.div_done;
      wtve_pkg::S_PAIR_NEXT: cmd.pair_next = 1'b1;
      wtve_pkg::S_AVG_GO:    cmd.div_avg = 1'b1;
      wtve_pkg::S_AVG_WAIT:  cmd.avg_acc = sts.div_done;
      wtve_pkg::S_DONE:      cmd.load_out = sts.out_free;
      default:               cmd.idle = 1'b0;
    endcase
  end

endmodule

// ===== rtl/wtve_dp.sv =====
// ----------------------------------------------------------------------------
// wtve_dp
// sample stores, track table, expiry compare, pair arithmetic, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtve_dp #(
  parameter int ROBOTS_PER_TEAM = 16,
  parameter int WINDOW_DEPTH    = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  wtve_pkg::cmd_t                         cmd,
  output wtve_pkg::sts_t                         sts,
  input  logic                                   cfg_wr_en,
  input  logic [wtve_pkg::WIN_W-1:0]             cfg_wr_data,
  input  logic [wtve_pkg::KIND_W-1:0]            track_kind,
  input  logic [wtve_pkg::ID_W-1:0]              robot_id,
  input  logic [wtve_pkg::TIME_W-1:0]            timestamp_us,
  input  logic signed [wtve_pkg::POS_W-1:0]      pos_x,
  input  logic signed [wtve_pkg::POS_W-1:0]      pos_y,
  input  logic signed [wtve_pkg::POS_W-1:0]      heading,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic                                   velocity_valid,
  output logic signed [wtve_pkg::VEL_W-1:0]      vel_x,
  output logic signed [wtve_pkg::VEL_W-1:0]      vel_y,
  output logic signed [wtve_pkg::VEL_W-1:0]      vel_heading,
  output logic [wtve_pkg::HELD_W-1:0]            samples_held
);

  localparam int NT     = 2 * ROBOTS_PER_TEAM + 1;
  localparam int BALL   = 2 * ROBOTS_PER_TEAM;
  localparam int TRK_W  = $clog2(NT);
  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int DEPTH  = NT * WINDOW_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int TW     = wtve_pkg::TIME_W;
  localparam int PW     = wtve_pkg::POSE_W;
  localparam int DW     = wtve_pkg::DIV_W;
  localparam int NCH    = wtve_pkg::NUM_CH;

  function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W-1:0] base,
                                                  input logic [CNT_W-1:0]  ofs);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
    if (s >= (CNT_W+1)'(WINDOW_DEPTH)) s = s - (CNT_W+1)'(WINDOW_DEPTH);
    return s[SLOT_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] st_addr(input logic [TRK_W-1:0]  trk,
                                                input logic [SLOT_W-1:0] slot);
    return ADDR_W'(trk) * ADDR_W'(WINDOW_DEPTH) + ADDR_W'(slot);
  endfunction

  function automatic logic signed [wtve_pkg::VEL_W-1:0] sat32(input logic signed [DW-1:0] v);
    if (v > DW'(64'sd2147483647))       return 32'sh7FFFFFFF;
    else if (v < -DW'(64'sd2147483648)) return 32'sh80000000;
    else                                return v[wtve_pkg::VEL_W-1:0];
  endfunction

  // sample stores, one row per track
  logic [TW-1:0]     time_mem [DEPTH];
  logic [PW-1:0]     pose_mem [DEPTH];
  logic [TW-1:0]     time_q;
  logic [PW-1:0]     pose_q;
  logic              st_we;
  logic [ADDR_W-1:0] st_waddr;
  logic [ADDR_W-1:0] st_raddr;
  logic [TW-1:0]     st_wtime;
  logic [PW-1:0]     st_wpose;

  // track table: head and fill count, invalid entries read as zero
  logic [SLOT_W-1:0] head_mem [NT];
  logic [CNT_W-1:0]  cnt_mem  [NT];
  logic [NT-1:0]     trk_vld;
  logic [SLOT_W-1:0] info_head_q;
  logic [CNT_W-1:0]  info_cnt_q;
  logic              inf_we;
  logic [TRK_W-1:0]  inf_waddr;
  logic [TRK_W-1:0]  inf_raddr;
  logic [SLOT_W-1:0] inf_whead;
  logic [CNT_W-1:0]  inf_wcnt;

  logic [wtve_pkg::WIN_W-1:0] win;
  logic [TRK_W-1:0]  cur_trk;
  logic              bad;
  logic [TW-1:0]     now_t;
  logic [PW-1:0]     pose_in;

  logic [TRK_W-1:0]  exp_trk;
  logic              exp_ball;
  logic [SLOT_W-1:0] e_head;
  logic [CNT_W-1:0]  e_cnt;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  w;
  logic              keep;

  logic [SLOT_W-1:0] v_head;
  logic [CNT_W-1:0]  v_n;
  logic [TW-1:0]     ta;
  logic [PW-1:0]     pa;
  logic signed [wtve_pkg::DT_W-1:0]   dt;
  logic signed [wtve_pkg::DIFF_W-1:0] dpos [NCH];
  logic [wtve_pkg::CH_W-1:0]          c;
  logic signed [wtve_pkg::PROD_W-1:0] prod;
  logic signed [DW-1:0]               sum [NCH];
  logic signed [wtve_pkg::VEL_W-1:0]  res [NCH];
  logic [wtve_pkg::HELD_W-1:0]        held;
  logic                               vv;

  logic              div_start;
  logic signed [DW-1:0] div_a;
  logic signed [DW-1:0] div_b;
  logic              div_done;
  logic signed [DW-1:0] div_q;

  logic [SLOT_W-1:0] app_slot;
  logic [SLOT_W-1:0] app_head;
  logic [CNT_W-1:0]  app_cnt;

  // ---------------- config ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= wtve_pkg::WIN_RESET;
    end else if (cfg_wr_en) begin
      win <= cfg_wr_data;
    end
  end

  // ---------------- input capture ----------------
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      bad     <= (track_kind == wtve_pkg::KIND_NONE) ||
                 (track_kind != wtve_pkg::KIND_BALL && 32'(robot_id) >= ROBOTS_PER_TEAM);
      if (track_kind == wtve_pkg::KIND_BALL) begin
        cur_trk <= TRK_W'(BALL);
      end else if (track_kind == wtve_pkg::KIND_OPP) begin
        cur_trk <= TRK_W'(ROBOTS_PER_TEAM) + TRK_W'(robot_id);
      end else begin
        cur_trk <= TRK_W'(robot_id);
      end
      now_t   <= timestamp_us;
      pose_in <= {heading, pos_y, pos_x};
    end
  end

  // ---------------- append slot ----------------
  always_comb begin
    if (info_cnt_q < CNT_W'(WINDOW_DEPTH)) begin
      app_slot = wrap_slot(info_head_q, info_cnt_q);
      app_head = info_head_q;
      app_cnt  = info_cnt_q + 1'b1;
    end else begin
      // full window: overwrite the oldest
      app_slot = info_head_q;
      app_head = wrap_slot(info_head_q, CNT_W'(1));
      app_cnt  = info_cnt_q;
    end
  end

  assign keep = !((time_q < now_t) && ((now_t - time_q) > TW'(win)));

  // ---------------- store ports ----------------
  always_comb begin
    st_we    = 1'b0;
    st_waddr = st_addr(cur_trk, app_slot);
    st_wtime = now_t;
    st_wpose = pose_in;
    if (cmd.append) begin
      st_we = 1'b1;
    end else if (cmd.exp_chk && keep) begin
      st_we    = 1'b1;
      st_waddr = st_addr(exp_trk, wrap_slot(e_head, w));
      st_wtime = time_q;
      st_wpose = pose_q;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      wtve_pkg::RD_SEL_A: st_raddr = st_addr(cur_trk, wrap_slot(v_head, k));
      wtve_pkg::RD_SEL_B: st_raddr = st_addr(cur_trk, wrap_slot(v_head, k + 1'b1));
      default:            st_raddr = st_addr(exp_trk, wrap_slot(e_head, k));
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      time_mem[st_waddr] <= st_wtime;
      pose_mem[st_waddr] <= st_wpose;
    end
    time_q <= time_mem[st_raddr];
    pose_q <= pose_mem[st_raddr];
  end

  // ---------------- track table ports ----------------
  assign inf_raddr = cmd.info_cur ? cur_trk : exp_trk;

  always_comb begin
    inf_we    = 1'b0;
    inf_waddr = cur_trk;
    inf_whead = app_head;
    inf_wcnt  = app_cnt;
    if (cmd.append) begin
      inf_we = 1'b1;
    end else if (cmd.exp_wb) begin
      inf_we    = 1'b1;
      inf_waddr = exp_trk;
      inf_whead = e_head;
      inf_wcnt  = w;
    end
  end

  always_ff @(posedge clk) begin
    if (inf_we) begin
      head_mem[inf_waddr] <= inf_whead;
      cnt_mem[inf_waddr]  <= inf_wcnt;
    end
    info_head_q <= trk_vld[inf_raddr] ? head_mem[inf_raddr] : '0;
    info_cnt_q  <= trk_vld[inf_raddr] ? cnt_mem[inf_raddr]  : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trk_vld <= '0;
    end else if (inf_we) begin
      trk_vld[inf_waddr] <= 1'b1;
    end
  end

  // ---------------- expiry sweep and pair counters ----------------
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      exp_ball <= (cur_trk == TRK_W'(BALL));
      exp_trk  <= (cur_trk == TRK_W'(BALL)) ? TRK_W'(BALL) : '0;
    end
    if (cmd.exp_load) begin
      e_head <= info_head_q;
      e_cnt  <= info_cnt_q;
      k      <= '0;
      w      <= '0;
    end
    if (cmd.exp_chk) begin
      k <= k + 1'b1;
      if (keep) w <= w + 1'b1;
    end
    if (cmd.exp_wb) exp_trk <= exp_trk + 1'b1;
    if (cmd.vel_load) begin
      v_head <= info_head_q;
      v_n    <= info_cnt_q;
      k      <= '0;
    end
    if (cmd.pair_next) k <= k + 1'b1;
  end

  // ---------------- pair arithmetic ----------------
  always_ff @(posedge clk) begin
    if (cmd.rd_b) begin
      ta <= time_q;
      pa <= pose_q;
    end
    if (cmd.dt_calc) begin
      dt <= $signed({1'b0, time_q}) - $signed({1'b0, ta});
      for (int i = 0; i < NCH; i++) begin
        dpos[i] <= wtve_pkg::DIFF_W'($signed(pose_q[i*wtve_pkg::POS_W +: wtve_pkg::POS_W]))
                 - wtve_pkg::DIFF_W'($signed(pa[i*wtve_pkg::POS_W +: wtve_pkg::POS_W]));
      end
    end
    if (cmd.mul) prod <= dpos[c] * wtve_pkg::US_PER_SEC;
    if (cmd.load_in || cmd.vel_load) begin
      for (int i = 0; i < NCH; i++) begin
        sum[i] <= '0;
        res[i] <= '0;
      end
    end
    if (cmd.pair_acc) sum[c] <= sum[c] + div_q;
    if (cmd.avg_acc)  res[c] <= sat32(div_q);
  end

  always_ff @(posedge clk) begin
    if (cmd.dt_calc || cmd.pair_next) begin
      c <= '0;
    end else if (cmd.pair_acc || cmd.avg_acc) begin
      c <= c + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      held <= '0;
      vv   <= 1'b0;
    end else if (cmd.vel_load) begin
      held <= wtve_pkg::HELD_W'(info_cnt_q);
      vv   <= (info_cnt_q >= CNT_W'(2));
    end
  end

  assign div_start = cmd.div_pair || cmd.div_avg;
  assign div_a     = cmd.div_avg ? sum[c] : DW'(prod);
  assign div_b     = cmd.div_avg ? $signed(DW'(v_n - 1'b1)) : DW'(dt);

  wtve_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      velocity_valid <= vv;
      vel_x          <= res[0];
      vel_y          <= res[1];
      vel_heading    <= res[2];
      samples_held   <= held;
    end
  end

  // ---------------- status ----------------
  always_comb begin
    sts.bad          = bad;
    sts.exp_cnt_zero = (info_cnt_q == '0);
    sts.exp_k_last   = ((CNT_W+1)'(k) + 1'b1) == (CNT_W+1)'(e_cnt);
    sts.exp_trk_last = exp_ball || (exp_trk == TRK_W'(BALL - 1));
    sts.vel_short    = (info_cnt_q < CNT_W'(2));
    sts.dt_zero      = (time_q == ta);
    sts.ch_last      = (c == wtve_pkg::CH_W'(NCH - 1));
    sts.pair_last    = ((CNT_W+1)'(k) + (CNT_W+1)'(2)) == (CNT_W+1)'(v_n);
    sts.div_done     = div_done;
    sts.out_free     = !out_valid || !out_stall;
  end

endmodule

// ===== rtl/windowed_track_velocity_estimator_unit.sv =====
// an invalid track skips to the result; else append, expiry sweep, per sample pair with
//   nonzero dt a divide per channel, and a divide per channel to average if two or more
//   samples are held; robot samples sweep all robot tracks, ball ones only the ball track
// throughput: one transaction in flight; the next is taken the cycle after the result loads
// reset: synchronous rst clears the track table valid bits and window time to 500000 us;
//   sample stores are not cleared, no clearing pass
// ----------------------------------------------------------------------------
// windowed_track_velocity_estimator_unit
// per-track sliding window of pose samples with mean finite-difference velocity
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "windowed_track_velocity_estimator_unit_macros.svh"

module windowed_track_velocity_estimator_unit #(
  parameter int ROBOTS_PER_TEAM = 16,
  parameter int WINDOW_DEPTH    = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [wtve_pkg::WIN_W-1:0]             cfg_wr_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [wtve_pkg::KIND_W-1:0]            track_kind,
  input  logic [wtve_pkg::ID_W-1:0]              robot_id,
  input  logic [wtve_pkg::TIME_W-1:0]            timestamp_us,
  input  logic signed [wtve_pkg::POS_W-1:0]      pos_x,
  input  logic signed [wtve_pkg::POS_W-1:0]      pos_y,
  input  logic signed [wtve_pkg::POS_W-1:0]      heading,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   velocity_valid,
  output logic signed [wtve_pkg::VEL_W-1:0]      vel_x,
  output logic signed [wtve_pkg::VEL_W-1:0]      vel_y,
  output logic signed [wtve_pkg::VEL_W-1:0]      vel_heading,
  output logic [wtve_pkg::HELD_W-1:0]            samples_held
);

  wtve_pkg::cmd_t cmd;
  wtve_pkg::sts_t sts;

  assign in_stall = !cmd.idle;

  wtve_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  wtve_dp #(
    .ROBOTS_PER_TEAM (ROBOTS_PER_TEAM),
    .WINDOW_DEPTH    (WINDOW_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .track_kind     (track_kind),
    .robot_id       (robot_id),
    .timestamp_us   (timestamp_us),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .heading        (heading),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .velocity_valid (velocity_valid),
    .vel_x          (vel_x),
    .vel_y          (vel_y),
    .vel_heading    (vel_heading),
    .samples_held   (samples_held)
  );

  // a taken transaction keeps the input closed while it is worked on
  `WTVE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open after accept")

  // a result without a velocity carries zero velocities
  `WTVE_ASSERT_SAME(a_zero_when_invalid, out_valid && !velocity_valid, vel_x == 0 && vel_y == 0 && vel_heading == 0, "nonzero velocity on invalid result")

  // after a result load the input reopens with the result presented
  `WTVE_ASSERT_NEXT(a_load_while_busy, cmd.load_out, in_stall == 1'b0 && out_valid, "result load out of sequence")

endmodule
